// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rqr_pkg.sv
package rqr_pkg;

  // queue depth and field widths
  localparam int CAPACITY = 512;
  localparam int ID_W     = 16;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int COUNT_W  = 10;

  // internal widths derived from the depth
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LVL_W = $clog2(IDX_W + 1);

  // opcodes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // per-cell control from the queue controller
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/core/rqr_cell.sv
module rqr_cell (
  input  logic                     clk,
  input  rqr_pkg::cell_ctl_t       ctl,
  input  logic [rqr_pkg::ID_W-1:0] key,
  input  logic [rqr_pkg::ID_W-1:0] next_data,
  input  logic                     occupied,
  output logic [rqr_pkg::ID_W-1:0] data,
  output logic                     match
);

  logic [rqr_pkg::ID_W-1:0] data_r;

  // load a new tail entry or take the younger neighbor's entry
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= key;
    end else if (ctl.shift) begin
      data_r <= next_data;
    end
  end

  // compare against the key, only for live entries
  assign match = occupied && (data_r == key);
  assign data  = data_r;

endmodule

// File: rtl/core/rqr_prefix.sv
module rqr_prefix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rqr_pkg::CAPACITY-1:0] match_in,
  output logic [rqr_pkg::CAPACITY-1:0] pfx,
  output logic                         pfx_valid
);

  localparam logic [rqr_pkg::LVL_W-1:0] LAST_LVL = rqr_pkg::LVL_W'(rqr_pkg::IDX_W - 1);

  logic [rqr_pkg::CAPACITY-1:0] pfx_r;
  logic [rqr_pkg::LVL_W-1:0]    lvl_r;
  logic                         busy_r;
  logic                         valid_r;
  logic [rqr_pkg::IDX_W-1:0]    step_amt;

  // distance doubles each step
  assign step_amt = rqr_pkg::IDX_W'(1) << lvl_r;

  // log-step inclusive prefix or, one level per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      pfx_r <= match_in;
    end else if (busy_r) begin
      pfx_r <= pfx_r | (pfx_r << step_amt);
    end
  end

  // level counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= '0;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      lvl_r   <= '0;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else if (busy_r) begin
      lvl_r <= lvl_r + rqr_pkg::LVL_W'(1);
      if (lvl_r == LAST_LVL) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  assign pfx       = pfx_r;
  assign pfx_valid = valid_r;

endmodule

// File: rtl/core/ready_queue_with_removal.sv
// Put, get and unused opcodes: result registered in the cycle after the item is accepted,
// one item per cycle while the result side keeps up.
// Remove: the result is registered once the log-step prefix scan that finds the oldest
// match completes and the result side is free; no item is taken meanwhile.
// Reset clears the state, entry count and output valid; entries are not cleared and are
// never read before being written, so no clearing pass is needed.
module ready_queue_with_removal (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rqr_pkg::OP_W-1:0]    in_opcode,
  input  logic [rqr_pkg::ID_W-1:0]    in_proc_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rqr_pkg::ST_W-1:0]    out_status,
  output logic [rqr_pkg::ID_W-1:0]    out_id,
  output logic [rqr_pkg::COUNT_W-1:0] out_count,
  output logic                        out_is_empty
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                       state_r;
  logic [rqr_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rqr_pkg::ID_W-1:0]     key_r;
  logic                         out_valid_r;
  logic [rqr_pkg::ST_W-1:0]     out_status_r, status_nxt;
  logic [rqr_pkg::ID_W-1:0]     out_id_r, id_nxt;
  logic [rqr_pkg::COUNT_W-1:0]  out_count_r;
  logic                         out_is_empty_r;

  logic                         out_free, accept, commit, found, load_res;
  logic                         is_full, is_empty, do_get, do_put, start_scan;
  logic [rqr_pkg::ID_W-1:0]     key;
  logic [rqr_pkg::ID_W-1:0]     cell_data [rqr_pkg::CAPACITY];
  logic [rqr_pkg::CAPACITY-1:0] cell_match;
  logic [rqr_pkg::CAPACITY-1:0] pfx;
  logic                         pfx_valid;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == S_SCAN) && pfx_valid && out_free;

  // a result is loaded on a non-remove item or at the end of a scan
  assign load_res = (accept && (in_opcode != rqr_pkg::OP_REMOVE)) || commit;

  // queue status decode
  assign is_full    = (cnt_r == rqr_pkg::CNT_W'(rqr_pkg::CAPACITY));
  assign is_empty   = (cnt_r == '0);
  assign do_put     = accept && (in_opcode == rqr_pkg::OP_PUT) && !is_full;
  assign do_get     = accept && (in_opcode == rqr_pkg::OP_GET) && !is_empty;
  assign start_scan = accept && (in_opcode == rqr_pkg::OP_REMOVE);
  assign found      = pfx[rqr_pkg::CAPACITY-1];

  // compare key: live input while idle, held id during the scan
  assign key = (state_r == S_IDLE) ? in_proc_id : key_r;

  // row of entry cells, oldest at index zero
  for (genvar i = 0; i < rqr_pkg::CAPACITY; i++) begin : g_cell
    rqr_pkg::cell_ctl_t       ctl;
    logic [rqr_pkg::ID_W-1:0] nbr;

    assign ctl.load  = do_put && (cnt_r == rqr_pkg::CNT_W'(i));
    assign ctl.shift = do_get || (commit && pfx[i]);

    if (i == rqr_pkg::CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    rqr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key),
      .next_data (nbr),
      .occupied  (rqr_pkg::CNT_W'(i) < cnt_r),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  // oldest-match search
  rqr_prefix u_prefix (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_scan),
    .match_in  (cell_match),
    .pfx       (pfx),
    .pfx_valid (pfx_valid)
  );

  // result and next count
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = rqr_pkg::ST_OK;
    id_nxt     = '0;
    if (commit) begin
      if (found) begin
        cnt_nxt = cnt_r - rqr_pkg::CNT_W'(1);
      end else begin
        status_nxt = rqr_pkg::ST_NOT_FOUND;
      end
    end else begin
      case (in_opcode)
        rqr_pkg::OP_PUT: begin
          if (is_full) begin
            status_nxt = rqr_pkg::ST_FULL;
          end else begin
            cnt_nxt = cnt_r + rqr_pkg::CNT_W'(1);
          end
        end
        rqr_pkg::OP_GET: begin
          if (is_empty) begin
            status_nxt = rqr_pkg::ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - rqr_pkg::CNT_W'(1);
            id_nxt  = cell_data[0];
          end
        end
        default: begin
          status_nxt = rqr_pkg::ST_OK;
        end
      endcase
    end
  end

  // controller state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_opcode == rqr_pkg::OP_REMOVE) begin
              state_r <= S_SCAN;
              key_r   <= in_proc_id;
            end else begin
              cnt_r          <= cnt_nxt;
              out_status_r   <= status_nxt;
              out_id_r       <= id_nxt;
              out_count_r    <= rqr_pkg::COUNT_W'(cnt_nxt);
              out_is_empty_r <= (cnt_nxt == '0);
            end
          end
        end
        S_SCAN: begin
          if (commit) begin
            state_r        <= S_IDLE;
            cnt_r          <= cnt_nxt;
            out_status_r   <= status_nxt;
            out_id_r       <= id_nxt;
            out_count_r    <= rqr_pkg::COUNT_W'(cnt_nxt);
            out_is_empty_r <= (cnt_nxt == '0);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_id       = out_id_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;

endmodule

// File: rtl/core/rqr_checker.sv
`include "assert_macros.svh"

module rqr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rqr_pkg::ST_W-1:0]    out_status,
  input logic [rqr_pkg::ID_W-1:0]    out_id,
  input logic [rqr_pkg::COUNT_W-1:0] out_count,
  input logic                        out_is_empty
);

  localparam logic [rqr_pkg::COUNT_W-1:0] FULL_COUNT = rqr_pkg::COUNT_W'(rqr_pkg::CAPACITY);

  // a stalled item holds
  `RQR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_id) && $stable(out_count), "stalled item changed")

  // empty flag agrees with the count while the queue cannot wrap the field
  `RQR_ASSERT_NOW(a_empty_flag, out_valid && (out_count != '0), !out_is_empty, "empty flag with nonzero count")

  // a failed get leaves an empty queue and no identifier
  `RQR_ASSERT_NOW(a_get_empty, out_valid && (out_status == rqr_pkg::ST_EMPTY), out_is_empty && (out_id == '0), "empty status with data")

  // full status reports the capacity
  `RQR_ASSERT_NOW(a_put_full, out_valid && (out_status == rqr_pkg::ST_FULL), (out_count == FULL_COUNT) && (out_id == '0), "full status with wrong count")

endmodule

bind ready_queue_with_removal rqr_checker u_rqr_checker (.*);
